### src/scpd_pkg.sv
// shared types, constants and config codes of the serial command packet decoder
package scpd_pkg;

    // frame layout and channel limits
    localparam int FRAME_BYTES    = 5;
    localparam int SERVO_CHANNELS = 4;
    localparam int MOTOR_CHANNELS = 4;
    localparam int IDX_W          = $clog2(FRAME_BYTES);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // servo mapping: pulse = 500 + angle*2000/180 us, duty = pulse*65535/20000
    localparam logic [7:0]  ANGLE_MAX   = 8'd180;
    localparam logic [11:0] PULSE_MIN   = 12'd500;
    // angle*100/9 as a reciprocal multiply, exact for angle up to 180
    localparam logic [14:0] ANGLE_MUL   = 15'd22756;
    localparam int          ANGLE_SHIFT = 11;
    // pulse*65535/20000 as a reciprocal multiply, exact for pulse up to 2500
    localparam logic [27:0] DUTY_MUL    = 28'd219898971;
    localparam int          DUTY_SHIFT  = 26;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SYNC_BYTE    = 3'd0,
        CFG_MOTOR_OPCODE = 3'd1,
        CFG_SERVO_OPCODE = 3'd2,
        CFG_RELAY_OPCODE = 3'd3,
        CFG_ACTIVE_LOW   = 3'd4
    } t_cfg_idx;

    // result kinds
    typedef enum logic [1:0] {
        KIND_MOTOR = 2'd0,
        KIND_SERVO = 2'd1,
        KIND_RELAY = 2'd2
    } t_kind;

    // configuration registers as seen by front and back
    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] motor_opcode;
        logic [7:0] servo_opcode;
        logic [7:0] relay_opcode;
        logic       relay_invert;
    } t_cfg;

    // classified command handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [1:0] channel;
        logic [7:0] arg2;
        logic       negate;
        logic       relay_on;
    } t_cmd;

endpackage

### src/scpd_front.sv
// front end: byte framing and command classification
module scpd_front
    import scpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    // frame bytes 1 to 4: command code and three arguments
    logic [7:0]       r_fld [4];
    logic [7:0]       n_fld [4];
    logic             accept;
    logic             is_start;
    logic             in_frame;
    logic             complete;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign is_start = (i_rx_byte == i_cfg.sync_byte);
    assign in_frame = accept && !is_start && (r_idx != '0);
    assign complete = in_frame && (r_idx == IDX_W'(FRAME_BYTES - 1));

    // framing position
    always_comb begin
        n_idx = r_idx;
        if (accept && is_start) begin
            n_idx = IDX_W'(1);
        end else if (complete) begin
            n_idx = '0;
        end else if (in_frame) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // frame store, the byte being taken shows through at once
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_fld[k] = (in_frame && r_idx == IDX_W'(k + 1)) ? i_rx_byte : r_fld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_fld[k] <= n_fld[k];
        end
    end

    // classify: motor first, then servo, then relay
    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = KIND_MOTOR;
        o_cmd.channel  = n_fld[1][1:0];
        o_cmd.arg2     = n_fld[2];
        o_cmd.negate   = (n_fld[3] > 8'd1);
        o_cmd.relay_on = (n_fld[1] != 8'd0);
        o_push         = 1'b0;
        if (n_fld[0] == i_cfg.motor_opcode) begin
            o_cmd.kind = KIND_MOTOR;
            o_push     = complete && (n_fld[1] < 8'(MOTOR_CHANNELS));
        end else if (n_fld[0] == i_cfg.servo_opcode) begin
            o_cmd.kind = KIND_SERVO;
            o_push     = complete && (n_fld[1] < 8'(SERVO_CHANNELS));
        end else if (n_fld[0] == i_cfg.relay_opcode) begin
            o_cmd.kind    = KIND_RELAY;
            o_cmd.channel = 2'd0;
            o_push        = complete;
        end
    end

endmodule

### src/scpd_fifo.sv
// short command queue between front and back
module scpd_fifo
    import scpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_empty,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### src/scpd_back.sv
// back end: executes commands into result fields, two register stages
module scpd_back
    import scpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_cmd_kind,
    output logic [1:0]        o_channel,
    output logic signed [8:0] o_motor_speed,
    output logic [7:0]        o_servo_angle,
    output logic [12:0]       o_servo_duty,
    output logic              o_relay_on,
    output logic              o_relay_pin_level
);

    // stage 1 registers
    logic        r_s1_valid;
    t_kind       r_s1_kind;
    logic [1:0]  r_s1_channel;
    logic [8:0]  r_s1_speed;
    logic [7:0]  r_s1_angle;
    logic [11:0] r_s1_pulse;
    logic        r_s1_on;
    logic        r_s1_level;

    // output registers
    logic        r_o_valid;
    t_kind       r_o_kind;
    logic [1:0]  r_o_channel;
    logic [8:0]  r_o_speed;
    logic [7:0]  r_o_angle;
    logic [12:0] r_o_duty;
    logic        r_o_on;
    logic        r_o_level;

    logic        out_en;
    logic        s1_en;
    logic [7:0]  angle;
    logic [22:0] angle_prod;
    logic [11:0] pulse;
    logic [8:0]  speed;
    logic [39:0] duty_prod;
    logic [12:0] duty;

    assign out_en = !r_o_valid || !i_stall;
    assign s1_en  = !r_s1_valid || out_en;
    assign o_pop  = s1_en && !i_empty;

    // stage 1: speed sign, angle clamp, pulse width in us
    always_comb begin
        angle      = (i_cmd.arg2 > ANGLE_MAX) ? ANGLE_MAX : i_cmd.arg2;
        angle_prod = 23'(angle) * 23'(ANGLE_MUL);
        pulse      = PULSE_MIN + angle_prod[ANGLE_SHIFT +: 12];
        speed      = i_cmd.negate ? (9'd0 - {1'b0, i_cmd.arg2}) : {1'b0, i_cmd.arg2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_kind    <= i_cmd.kind;
            r_s1_channel <= i_cmd.channel;
            r_s1_speed   <= speed;
            r_s1_angle   <= angle;
            r_s1_pulse   <= pulse;
            r_s1_on      <= i_cmd.relay_on;
            r_s1_level   <= i_cmd.relay_on ^ i_cfg.relay_invert;
        end
    end

    // stage 2: duty on the 0 to 65535 scale of the 20 ms period, 13 bits wide
    assign duty_prod = 40'(r_s1_pulse) * 40'(DUTY_MUL);
    assign duty      = duty_prod[DUTY_SHIFT +: 13];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_en) begin
            r_o_valid <= r_s1_valid;
        end
    end

    // fields that do not belong to the kind read as zero
    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_o_kind    <= r_s1_kind;
            r_o_channel <= r_s1_channel;
            r_o_speed   <= '0;
            r_o_angle   <= '0;
            r_o_duty    <= '0;
            r_o_on      <= 1'b0;
            r_o_level   <= 1'b0;
            case (r_s1_kind)
                KIND_MOTOR: begin
                    r_o_speed <= r_s1_speed;
                end
                KIND_SERVO: begin
                    r_o_angle <= r_s1_angle;
                    r_o_duty  <= duty;
                end
                KIND_RELAY: begin
                    r_o_on    <= r_s1_on;
                    r_o_level <= r_s1_level;
                end
                default: begin
                    r_o_speed <= '0;
                end
            endcase
        end
    end

    assign o_valid           = r_o_valid;
    assign o_cmd_kind        = r_o_kind;
    assign o_channel         = r_o_channel;
    assign o_motor_speed     = $signed(r_o_speed);
    assign o_servo_angle     = r_o_angle;
    assign o_servo_duty      = r_o_duty;
    assign o_relay_on        = r_o_on;
    assign o_relay_pin_level = r_o_level;

endmodule

### src/serial_command_packet_decoder_core.sv
// top level of the serial command packet decoder
// Takes one received byte per cycle unless stalled. A byte equal to the start byte opens
// a frame of five bytes (start, command, three arguments); bytes outside a frame are
// dropped. A complete relay frame, or motor or servo frame with channel below 4, gives
// one result through the queue entry, the pulse stage, then duty and output register. The
// front end stalls only while the two-entry command queue is full, which happens when the
// output side holds its stall for several completed commands in a row. Configuration
// writes take effect at once; the user, not the block, makes sure no command is in flight.
module serial_command_packet_decoder_core
    import scpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_cmd_kind,
    output logic [1:0]        o_channel,
    output logic signed [8:0] o_motor_speed,
    output logic [7:0]        o_servo_angle,
    output logic [12:0]       o_servo_duty,
    output logic              o_relay_on,
    output logic              o_relay_pin_level
);

    t_cfg r_cfg;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte    <= 8'd0;
            r_cfg.motor_opcode <= 8'd1;
            r_cfg.servo_opcode <= 8'd2;
            r_cfg.relay_opcode <= 8'd3;
            r_cfg.relay_invert <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SYNC_BYTE:    r_cfg.sync_byte    <= i_cfg_data;
                CFG_MOTOR_OPCODE: r_cfg.motor_opcode <= i_cfg_data;
                CFG_SERVO_OPCODE: r_cfg.servo_opcode <= i_cfg_data;
                CFG_RELAY_OPCODE: r_cfg.relay_opcode <= i_cfg_data;
                CFG_ACTIVE_LOW:   r_cfg.relay_invert <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // framing and classification
    scpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    // command queue
    scpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_empty (empty),
        .o_full  (full),
        .o_cmd   (pop_cmd)
    );

    // command execution
    scpd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_empty           (empty),
        .i_cmd             (pop_cmd),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_cmd_kind        (o_cmd_kind),
        .o_channel         (o_channel),
        .o_motor_speed     (o_motor_speed),
        .o_servo_angle     (o_servo_angle),
        .o_servo_duty      (o_servo_duty),
        .o_relay_on        (o_relay_on),
        .o_relay_pin_level (o_relay_pin_level)
    );

endmodule

### src/scpd_checker.sv
// port-level checks of the decoder core and their bind
module scpd_checker
    import scpd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_cmd_kind,
    input logic [1:0]        o_channel,
    input logic signed [8:0] o_motor_speed,
    input logic [7:0]        o_servo_angle,
    input logic [12:0]       o_servo_duty,
    input logic              o_relay_on,
    input logic              o_relay_pin_level
);

    // a held result keeps its kind, channel, speed and duty
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cmd_kind) && $stable(o_channel)
            && $stable(o_motor_speed) && $stable(o_servo_duty))
        else $error("stalled result changed");

    // relay results carry nothing from the motor or servo paths
    a_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cmd_kind == KIND_RELAY |-> o_channel == 2'd0
            && o_motor_speed == 9'sd0 && o_servo_angle == 8'd0 && o_servo_duty == 13'd0)
        else $error("relay result has stray fields");

    // servo angle clamped, duty inside the 500 to 2500 us window, no motor or relay fields
    a_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cmd_kind == KIND_SERVO |-> o_servo_angle <= ANGLE_MAX
            && o_servo_duty >= 13'd1638 && o_servo_duty <= 13'd8191
            && o_motor_speed == 9'sd0 && !o_relay_on && !o_relay_pin_level)
        else $error("servo result out of range");

    // motor results never show relay or servo fields, nor a speed of -256
    a_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cmd_kind == KIND_MOTOR |-> o_servo_angle == 8'd0
            && o_servo_duty == 13'd0 && !o_relay_on && !o_relay_pin_level
            && o_motor_speed != -9'sd256)
        else $error("motor result has stray fields");

endmodule

bind serial_command_packet_decoder_core scpd_checker u_scpd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_cmd_kind        (o_cmd_kind),
    .o_channel         (o_channel),
    .o_motor_speed     (o_motor_speed),
    .o_servo_angle     (o_servo_angle),
    .o_servo_duty      (o_servo_duty),
    .o_relay_on        (o_relay_on),
    .o_relay_pin_level (o_relay_pin_level)
);

### test/serial_command_packet_decoder_core_tb.sv
// testbench for the serial command packet decoder: directed and random framed bytes checked against a predictor
`timescale 1ns / 100ps

module serial_command_packet_decoder_core_tb;
    import scpd_pkg::*;

    // servo mapping and run limits
    localparam int unsigned MAX_DEG      = 180;
    localparam int unsigned MIN_PULSE_US = 500;
    localparam int unsigned SPAN_US      = 2000;
    localparam int unsigned FRAME_US     = 20000;
    localparam int unsigned DUTY_FULL    = 65535;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          PHASE_ITEMS  = 304;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [7:0]  DIR_START    = 8'hA5;
    localparam logic [7:0]  DIR_UNKNOWN  = 8'hFE;

    // one decoded command as it leaves the block
    typedef struct packed {
        t_kind              kind;
        logic [1:0]         channel;
        logic signed [8:0]  speed;
        logic [7:0]         angle;
        logic [12:0]        duty;
        logic               relay_on;
        logic               pin_level;
    } t_cmd_result;

    // predicts the decoded commands and matches them against what comes out
    class cmd_frame_tracker;
        logic [7:0]  sync_byte;
        logic [7:0]  motor_op;
        logic [7:0]  servo_op;
        logic [7:0]  relay_op;
        logic        active_low;
        int          pos;
        logic [7:0]  frame[FRAME_BYTES];
        t_cmd_result due_cmds[$];
        int          faults;
        int          kind_seen[3];

        function new();
            sync_byte  = 8'd0;
            motor_op   = 8'd1;
            servo_op   = 8'd2;
            relay_op   = 8'd3;
            active_low = 1'b0;
            pos        = 0;
            faults     = 0;
            kind_seen  = '{0, 0, 0};
        endfunction

        function void set_reg(t_cfg_idx idx, logic [7:0] value);
            case (idx)
                CFG_SYNC_BYTE:    sync_byte  = value;
                CFG_MOTOR_OPCODE: motor_op   = value;
                CFG_SERVO_OPCODE: servo_op   = value;
                CFG_RELAY_OPCODE: relay_op   = value;
                CFG_ACTIVE_LOW:   active_low = value[0];
                default: ;
            endcase
        endfunction

        // decode a complete frame, 0 when it gives no command
        function bit decode(output t_cmd_result r);
            logic [7:0]  op;
            logic [7:0]  a1;
            logic [7:0]  a2;
            logic [7:0]  a3;
            logic [8:0]  mag;
            int unsigned deg;
            int unsigned pulse;
            op  = frame[1];
            a1  = frame[2];
            a2  = frame[3];
            a3  = frame[4];
            r   = '0;
            mag = {1'b0, a2};
            if (op == motor_op) begin
                if (a1 >= MOTOR_CHANNELS) return 1'b0;
                r.kind    = KIND_MOTOR;
                r.channel = a1[1:0];
                r.speed   = (a3 > 8'd1) ? -mag : mag;
                return 1'b1;
            end
            if (op == servo_op) begin
                if (a1 >= SERVO_CHANNELS) return 1'b0;
                deg       = (a2 > MAX_DEG) ? MAX_DEG : a2;
                pulse     = MIN_PULSE_US + deg * SPAN_US / MAX_DEG;
                r.kind    = KIND_SERVO;
                r.channel = a1[1:0];
                r.angle   = deg[7:0];
                r.duty    = 13'(pulse * DUTY_FULL / FRAME_US);
                return 1'b1;
            end
            if (op == relay_op) begin
                r.kind      = KIND_RELAY;
                r.relay_on  = (a1 != 8'd0);
                r.pin_level = r.relay_on ^ active_low;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // note an accepted byte; returns 1 when it went into a frame
        function bit take_byte(logic [7:0] b);
            t_cmd_result r;
            if (b == sync_byte) pos = 0;
            if (pos == 0 && b != sync_byte) return 1'b0;
            frame[pos] = b;
            pos++;
            if (pos >= FRAME_BYTES) begin
                pos = 0;
                if (decode(r)) due_cmds.push_back(r);
            end
            return 1'b1;
        endfunction

        function void report_pair(string what, t_cmd_result w, t_cmd_result g);
            faults++;
            if (faults <= 10) begin
                $display("%s: want kind=%0d ch=%0d spd=%0d ang=%0d duty=%0d on=%0b pin=%0b",
                         what, w.kind, w.channel, $signed(w.speed), w.angle, w.duty,
                         w.relay_on, w.pin_level);
                $display("%s:  got kind=%0d ch=%0d spd=%0d ang=%0d duty=%0d on=%0b pin=%0b",
                         what, g.kind, g.channel, $signed(g.speed), g.angle, g.duty,
                         g.relay_on, g.pin_level);
            end
        endfunction

        // compare one result with the oldest expected command
        function void match_result(t_cmd_result got);
            t_cmd_result want;
            bit          bad;
            if (due_cmds.size() == 0) begin
                report_pair("unexpected result", '0, got);
                return;
            end
            want = due_cmds.pop_front();
            bad  = (got.kind !== want.kind) || (got.channel !== want.channel)
                || (got.speed !== want.speed) || (got.angle !== want.angle)
                || (got.duty !== want.duty) || (got.relay_on !== want.relay_on)
                || (got.pin_level !== want.pin_level);
            if (bad) report_pair("mismatch", want, got);
            else kind_seen[want.kind]++;
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [2:0]        i_cfg_idx  = CFG_SYNC_BYTE;
    logic [7:0]        i_cfg_data = 8'd0;
    logic              i_valid    = 1'b0;
    logic [7:0]        i_rx_byte  = 8'd0;
    logic              i_stall    = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_cmd_kind;
    logic [1:0]        o_channel;
    logic signed [8:0] o_motor_speed;
    logic [7:0]        o_servo_angle;
    logic [12:0]       o_servo_duty;
    logic              o_relay_on;
    logic              o_relay_pin_level;

    cmd_frame_tracker tracker = new();
    t_cmd_result      seen_cmd;
    bit               quiet = 1'b0;
    int               cycles = 0;
    int               sent = 0;
    int               taken = 0;
    int               setups = 0;

    serial_command_packet_decoder_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_cmd_kind        (o_cmd_kind),
        .o_channel         (o_channel),
        .o_motor_speed     (o_motor_speed),
        .o_servo_angle     (o_servo_angle),
        .o_servo_duty      (o_servo_duty),
        .o_relay_on        (o_relay_on),
        .o_relay_pin_level (o_relay_pin_level)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // random stall on the result side
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 37);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_cmd.kind      = t_kind'(o_cmd_kind);
            seen_cmd.channel   = o_channel;
            seen_cmd.speed     = o_motor_speed;
            seen_cmd.angle     = o_servo_angle;
            seen_cmd.duty      = o_servo_duty;
            seen_cmd.relay_on  = o_relay_on;
            seen_cmd.pin_level = o_relay_pin_level;
            tracker.match_result(seen_cmd);
        end
    end

    // single register write, write enable left high for the caller
    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        tracker.set_reg(idx, value);
    endtask

    task automatic apply_setup(input logic [7:0] start, input logic [7:0] motor,
                               input logic [7:0] servo, input logic [7:0] relay,
                               input logic inv);
        write_reg(CFG_SYNC_BYTE, start);
        write_reg(CFG_MOTOR_OPCODE, motor);
        write_reg(CFG_SERVO_OPCODE, servo);
        write_reg(CFG_RELAY_OPCODE, relay);
        write_reg(CFG_ACTIVE_LOW, {7'd0, inv});
        i_cfg_we <= 1'b0;
        setups++;
    endtask

    // offer one byte, with random idle cycles ahead of it unless quiet
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (tracker.take_byte(b)) taken++;
        sent++;
    endtask

    // wait until every expected command is out and the pipeline is empty
    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.due_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one chunk of random traffic: mostly frames, some cut short, some noise
    task automatic random_chunk();
        int         pick;
        int         len;
        logic [7:0] fr[FRAME_BYTES];
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_byte(8'($urandom_range(255)));
        end else begin
            fr[0] = tracker.sync_byte;
            case ($urandom_range(3))
                0: fr[1] = tracker.motor_op;
                1: fr[1] = tracker.servo_op;
                2: fr[1] = tracker.relay_op;
                default: fr[1] = 8'($urandom_range(255));
            endcase
            fr[2] = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
            case ($urandom_range(7))
                0: fr[3] = 8'd0;
                1: fr[3] = 8'd180;
                2: fr[3] = 8'd181;
                3: fr[3] = 8'd255;
                default: fr[3] = 8'($urandom_range(255));
            endcase
            case ($urandom_range(4))
                0: fr[4] = 8'd0;
                1: fr[4] = 8'd1;
                2: fr[4] = 8'd2;
                3: fr[4] = 8'd255;
                default: fr[4] = 8'($urandom_range(255));
            endcase
            len = (pick < 20) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
            for (int k = 0; k < len; k++) send_byte(fr[k]);
        end
    endtask

    task automatic random_phase();
        int mark;
        mark = taken;
        while (taken - mark < PHASE_ITEMS) random_chunk();
        drain();
    endtask

    // main sequence
    initial begin
        logic [7:0] directed[$];
        directed = '{
            8'h00,
            DIR_START, 8'h01, 8'h00, 8'hFF, 8'h02,
            DIR_START, 8'h02, 8'h03, DIR_START, 8'h02, 8'h00, 8'hFF, 8'h00,
            DIR_START, 8'h01, 8'h04, 8'h10, 8'h00,
            DIR_START, 8'h03, 8'hFF, 8'h00, 8'h00,
            DIR_START, DIR_UNKNOWN, 8'h00, 8'h00, 8'h00
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stray byte, motor reverse, restart inside a frame with
        // a clamped servo angle, bad motor channel, inverted relay, unknown code
        apply_setup(DIR_START, 8'h01, 8'h02, 8'h03, 1'b1);
        foreach (directed[k]) send_byte(directed[k]);
        drain();

        // reset values again, then extremes
        apply_setup(8'h00, 8'h01, 8'h02, 8'h03, 1'b0);
        random_phase();
        apply_setup(8'hFF, 8'h00, 8'hFE, 8'h80, 1'b1);
        random_phase();

        // all three codes equal, motor takes them; no idling on either side
        quiet = 1'b1;
        apply_setup(8'h7E, 8'h42, 8'h42, 8'h42, 1'b0);
        random_phase();
        quiet = 1'b0;

        // servo and relay share a code, servo takes it
        apply_setup(8'h3C, 8'h10, 8'h20, 8'h20, 1'b1);
        random_phase();

        apply_setup(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        random_phase();

        $display("%0d bytes sent over %0d register settings, %0d of them inside frames",
                 sent, setups, taken);
        $display("checked %0d motor, %0d servo and %0d relay commands, %0d mismatches",
                 tracker.kind_seen[KIND_MOTOR], tracker.kind_seen[KIND_SERVO],
                 tracker.kind_seen[KIND_RELAY], tracker.faults);
        if (tracker.faults == 0 && tracker.due_cmds.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/scpd_pkg.sv
src/scpd_front.sv
src/scpd_fifo.sv
src/scpd_back.sv
src/serial_command_packet_decoder_core.sv
src/scpd_checker.sv
test/serial_command_packet_decoder_core_tb.sv
